// File: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// shared types and codes for the stack machine execute unit
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH   = 1024;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int WORD_WIDTH    = 32;

    typedef enum logic [4:0] {
        OP_HALT  = 5'd0,
        OP_STORE = 5'd1,
        OP_JF    = 5'd2,
        OP_JT    = 5'd3,
        OP_GOTO  = 5'd4,
        OP_DATA  = 5'd5,
        OP_LDI   = 5'd6,
        OP_LDV   = 5'd7,
        OP_RD    = 5'd8,
        OP_WR    = 5'd9,
        OP_LT    = 5'd10,
        OP_EQ    = 5'd11,
        OP_GT    = 5'd12,
        OP_ADD   = 5'd13,
        OP_SUB   = 5'd14,
        OP_MUL   = 5'd15,
        OP_DIV   = 5'd16,
        OP_PWR   = 5'd17
    } t_op;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_OPC   = 3'd1;
    localparam logic [2:0] ERR_STACK = 3'd2;
    localparam logic [2:0] ERR_DIV0  = 3'd3;
    localparam logic [2:0] ERR_JUMP  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_EXEC,
        S_ITER,
        S_WB,
        S_TOP,
        S_TOPW,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd_a;
        logic rd_b;
        logic exec;
        logic iter_start;
        logic iter_step;
        logic wb;
        logic top_rd;
        logic top_cap;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic need_iter;
        logic iter_done;
    } t_sts;

endpackage

// File: hdl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// execute unit of an 18-opcode stack machine with a word stack in ram
// ----------------------------------------------------------------------------
// sequence: input transfer, two stack reads, execute, an iteration phase that
// runs the bit-serial divide and the square-and-multiply power (mult uses it too),
// write-back, top read and capture, output load (held while the output is stalled);
// a new transfer is taken only once the previous result sits in the output register
// reset: i_rst_n synchronous active low; a clearing pass over every stack address
// zeroes the stack ram before the first transfer is taken
module stack_machine_execute_unit
    import sme_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [9:0]   i_cfg_wdata,   // frame_base
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // op[4:0] arg[36:5] read_value[68:37]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata   // next_pc write_valid write_value halted
                                        // error_code top_index top_value
);

    logic [9:0] r_frame_base;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frame_base <= '0;
        else if (i_cfg_we) r_frame_base <= i_cfg_wdata;
    end

    t_cmd cmd;
    t_sts sts;
    logic in_fire;
    logic r_ovalid;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_busy(r_ovalid && !m_axis_tready), .i_sts(sts),
        .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    logic [9:0]  npc, tix;
    logic        wv, hl;
    logic [2:0]  ec;
    logic [31:0] wval, tval;

    sme_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_op(s_axis_tdata[4:0]), .i_arg(s_axis_tdata[36:5]),
        .i_read_value(s_axis_tdata[68:37]), .i_frame_base(r_frame_base),
        .o_next_pc(npc), .o_write_valid(wv), .o_write_value(wval),
        .o_halted(hl), .o_error_code(ec), .o_top_index(tix), .o_top_value(tval)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, tval, tix, ec, hl, wval, wv, npc};

    // no new instruction while one is in flight: ready drops in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready) else $error("ready after accept");
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(r_ovalid && !m_axis_tready)) else $error("overwrite");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[46:44] <= 3'd4) else $error("bad error code");

endmodule

// File: hdl/sme_ctrl.sv
// ----------------------------------------------------------------------------
// sme_ctrl
// sequencing state machine for the execute unit
// ----------------------------------------------------------------------------
module sme_ctrl
    import sme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_a = 1'b1;
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_b = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_iter) begin
                    o_cmd.iter_start = 1'b1;
                    n_state = S_ITER;
                end else begin
                    n_state = S_WB;
                end
            end
            S_ITER: begin
                o_cmd.iter_step = 1'b1;
                if (i_sts.iter_done) n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state = S_TOP;
            end
            S_TOP: begin
                o_cmd.top_rd = 1'b1;
                n_state = S_TOPW;
            end
            S_TOPW: begin
                o_cmd.top_cap = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hdl/sme_dp.sv
// ----------------------------------------------------------------------------
// sme_dp
// stack memory, pointers, alu and iterative divide / power unit
// ----------------------------------------------------------------------------
module sme_dp
    import sme_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cmd                              i_cmd,
    output t_sts                              o_sts,
    input  logic [4:0]                        i_op,
    input  logic signed [31:0]                i_arg,
    input  logic signed [31:0]                i_read_value,
    input  logic [9:0]                        i_frame_base,
    output logic [$clog2(PROGRAM_DEPTH)-1:0]  o_next_pc,
    output logic                              o_write_valid,
    output logic [WORD_WIDTH-1:0]             o_write_value,
    output logic                              o_halted,
    output logic [2:0]                        o_error_code,
    output logic [$clog2(STACK_DEPTH)-1:0]    o_top_index,
    output logic [WORD_WIDTH-1:0]             o_top_value
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rdata;
    logic [SW-1:0] r_raddr;
    logic          r_we;
    logic [SW-1:0] r_waddr;
    logic [W-1:0]  r_wdata;

    logic [SW-1:0] r_clr;
    logic          r_clr_done;
    logic [SW-1:0] r_top;
    logic [PW-1:0] r_pc;
    logic [4:0]    r_op;
    logic signed [33:0] r_arg;
    logic [W-1:0]  r_rd;
    logic [W-1:0]  r_x, r_y;

    // extended index math
    logic signed [33:0] t_s, f_s, d_s;
    logic t_ge1, t_push_ok, f_ok, a_stk_ok, a_pc_ok, d_ok;
    assign t_s   = 34'(r_top);
    assign f_s   = $signed({24'd0, i_frame_base}) + r_arg;
    assign d_s   = t_s + r_arg;
    assign t_ge1 = r_top != '0;
    assign t_push_ok = t_s + 34'sd1 < 34'(STACK_DEPTH);
    assign f_ok  = f_s >= 0 && f_s < 34'(STACK_DEPTH);
    assign a_stk_ok = r_arg >= 0 && r_arg < 34'(STACK_DEPTH);
    assign a_pc_ok  = r_arg >= 0 && r_arg < 34'(PROGRAM_DEPTH);
    assign d_ok  = d_s >= 0 && d_s < 34'(STACK_DEPTH);

    // read address selection per phase
    logic [SW-1:0] rd_addr_a, rd_addr_b;
    always_comb begin
        unique case (t_op'(r_op))
            OP_LDV:  rd_addr_a = f_s[SW-1:0];
            default: rd_addr_a = r_top - SW'(1);
        endcase
        rd_addr_b = r_top;
    end

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rdata <= r_mem[r_raddr];
    end

    // iterative unit
    logic [W-1:0] r_q, r_rem, r_dv, r_pb, r_pr, r_pe;
    logic         r_neg;
    logic [CW-1:0] r_cnt;
    logic [W:0]   rem_sh;
    logic [W-1:0] ax, ay;
    logic         sub_ok;
    logic [W-1:0] q_nx;
    assign ax = r_x[W-1] ? -r_x : r_x;
    assign ay = r_y[W-1] ? -r_y : r_y;
    assign rem_sh = {r_rem, r_q[W-1]};
    assign sub_ok = rem_sh >= {1'b0, r_dv};
    assign q_nx = {r_q[W-2:0], sub_ok};

    // execute results
    logic [2:0]    e_err;
    logic          e_we, e_wv, e_iter;
    logic [SW-1:0] e_waddr, e_top;
    logic [W-1:0]  e_wdata;
    logic [PW-1:0] e_pc, pc_inc;
    assign pc_inc = (32'(r_pc) + 32'd1 >= 32'(PROGRAM_DEPTH)) ? '0 : r_pc + PW'(1);

    always_comb begin
        e_err = ERR_NONE; e_we = 1'b0; e_wv = 1'b0; e_iter = 1'b0;
        e_waddr = r_top; e_wdata = '0; e_top = r_top; e_pc = pc_inc;
        unique case (t_op'(r_op))
            OP_HALT: ;
            OP_STORE: begin
                if (!t_ge1 || !a_stk_ok) e_err = ERR_STACK;
                else begin
                    e_we = 1'b1; e_waddr = r_arg[SW-1:0]; e_wdata = r_y;
                    e_top = r_top - SW'(1);
                end
            end
            OP_JF, OP_JT: begin
                if (!t_ge1) e_err = ERR_STACK;
                else if ((r_op == OP_JF && r_y == '0) ||
                         (r_op == OP_JT && r_y == W'(1))) begin
                    if (!a_pc_ok) e_err = ERR_JUMP;
                    else begin
                        e_pc = r_arg[PW-1:0]; e_top = r_top - SW'(1);
                    end
                end else e_top = r_top - SW'(1);
            end
            OP_GOTO: begin
                if (!a_pc_ok) e_err = ERR_JUMP;
                else e_pc = r_arg[PW-1:0];
            end
            OP_DATA: begin
                if (!d_ok) e_err = ERR_STACK;
                else e_top = d_s[SW-1:0];
            end
            OP_LDI: begin
                if (!t_push_ok) e_err = ERR_STACK;
                else begin
                    e_we = 1'b1; e_waddr = r_top + SW'(1);
                    e_wdata = W'(r_arg[31:0]);
                    if (W > 32) e_wdata = W'($signed(r_arg[31:0]));
                    e_top = r_top + SW'(1);
                end
            end
            OP_LDV: begin
                if (!t_push_ok || !f_ok) e_err = ERR_STACK;
                else begin
                    e_we = 1'b1; e_waddr = r_top + SW'(1); e_wdata = r_x;
                    e_top = r_top + SW'(1);
                end
            end
            OP_RD: begin
                if (!f_ok) e_err = ERR_STACK;
                else begin
                    e_we = 1'b1; e_waddr = f_s[SW-1:0]; e_wdata = r_rd;
                end
            end
            OP_WR: begin
                if (!t_ge1) e_err = ERR_STACK;
                else begin
                    e_wv = 1'b1; e_top = r_top - SW'(1);
                end
            end
            OP_LT, OP_EQ, OP_GT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PWR: begin
                if (!t_ge1) e_err = ERR_STACK;
                else if (r_op == OP_DIV && r_y == '0) e_err = ERR_DIV0;
                else begin
                    e_we = 1'b1; e_waddr = r_top - SW'(1);
                    e_top = r_top - SW'(1);
                    unique case (t_op'(r_op))
                        OP_LT:  e_wdata = W'($signed(r_x) < $signed(r_y));
                        OP_EQ:  e_wdata = W'(r_x == r_y);
                        OP_GT:  e_wdata = W'($signed(r_x) > $signed(r_y));
                        OP_ADD: e_wdata = r_x + r_y;
                        OP_SUB: e_wdata = r_x - r_y;
                        default: e_iter = 1'b1;
                    endcase
                end
            end
            default: e_err = ERR_OPC;
        endcase
    end

    // pending result registers
    logic [2:0]    r_err;
    logic          r_pwe, r_wv, r_halt;
    logic [SW-1:0] r_pwaddr, r_ntop;
    logic [W-1:0]  r_pwdata, r_wval, r_topv;
    logic [PW-1:0] r_npc;
    logic [1:0]    r_mode; // 0 alu, 1 div, 2 pwr and mult

    logic [W-1:0] mprod;
    assign mprod = r_pr * r_pb;

    always_comb begin
        r_raddr = r_clr;
        if (i_cmd.rd_a) r_raddr = rd_addr_a;
        else if (i_cmd.rd_b) r_raddr = rd_addr_b;
        else if (i_cmd.top_rd) r_raddr = r_ntop;
    end

    logic [W-1:0] sq;
    assign sq = r_pb * r_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_top <= '0; r_pc <= '0; r_we <= 1'b0;
            r_clr_done <= 1'b0;
        end else begin
            r_we <= i_cmd.clr_step || (i_cmd.wb && r_pwe);
            if (i_cmd.clr_step) begin
                r_waddr <= r_clr; r_wdata <= '0;
                r_clr <= r_clr + SW'(1);
                r_clr_done <= r_clr == SW'(STACK_DEPTH - 1);
            end else if (i_cmd.wb) begin
                r_waddr <= r_pwaddr;
                r_wdata <= r_mode == 2'd1 ? r_q : (r_mode == 2'd2 ? r_pr : r_pwdata);
                r_top <= r_ntop; r_pc <= r_npc;
            end
        end
    end
    assign o_sts.clr_done = r_clr_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_arg <= 34'(i_arg); r_rd <= W'(i_read_value);
        end
        if (i_cmd.rd_b) r_x <= r_rdata;
        if (i_cmd.exec) begin
            r_y <= r_rdata;
        end
        if (i_cmd.iter_start) begin
            // r_y is captured at exec, so the decision is made in the next cycle
        end
        // the word just written to the new top is still in the write register
        if (i_cmd.top_cap) r_topv <= (r_pwe && r_pwaddr == r_ntop) ? r_wdata : r_rdata;
    end

    // second exec-phase register: evaluate after r_y lands
    logic r_ev;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else r_ev <= i_cmd.exec;
    end

    assign o_sts.need_iter = 1'b1;
    // iteration phase: first cycle (r_ev) latches execute results
    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_step && r_ev) begin
            r_err <= e_err; r_pwe <= e_we; r_wv <= e_wv; r_halt <= r_op == OP_HALT;
            r_pwaddr <= e_waddr; r_ntop <= e_top; r_npc <= e_pc; r_pwdata <= e_wdata;
            r_wval <= e_wv ? r_y : '0;
            r_neg <= r_x[W-1] ^ r_y[W-1];
            r_q <= ax; r_rem <= '0; r_dv <= ay;
            r_pb <= r_x;
            if (e_iter && r_op == OP_MUL) begin
                // one multiply step: pr * pb with exponent 1
                r_mode <= 2'd2; r_pe <= W'(1); r_pr <= r_y;
                r_cnt <= CW'(1);
            end else if (e_iter && r_op == OP_DIV) begin
                r_mode <= 2'd1; r_pe <= r_y; r_pr <= W'(1);
                r_cnt <= CW'(W);
            end else if (e_iter && r_y[W-1]) begin
                r_mode <= 2'd2; r_pe <= r_y; r_cnt <= '0;
                r_pr <= (r_x == W'(1)) ? W'(1) :
                        (r_x == '1) ? (r_y[0] ? '1 : W'(1)) : '0;
            end else if (e_iter) begin
                r_mode <= 2'd2; r_pe <= r_y; r_pr <= W'(1);
                r_cnt <= CW'(W);
            end else begin
                r_mode <= 2'd0; r_pe <= r_y; r_pr <= W'(1);
                r_cnt <= '0;
            end
        end else if (i_cmd.iter_step && r_cnt != '0) begin
            if (r_mode == 2'd1) begin
                r_cnt <= r_cnt - CW'(1);
                r_rem <= sub_ok ? W'(rem_sh - {1'b0, r_dv}) : rem_sh[W-1:0];
                r_q <= (r_cnt == CW'(1) && r_neg) ? -q_nx : q_nx;
            end else begin
                if (r_pe[0]) r_pr <= mprod;
                r_pb <= sq;
                r_pe <= r_pe >> 1;
                r_cnt <= ((r_pe >> 1) == '0) ? '0 : r_cnt - CW'(1);
            end
        end
    end
    assign o_sts.iter_done = !r_ev && (r_cnt == '0 ||
        (r_mode == 2'd2 && r_pe == '0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_next_pc <= r_npc; o_write_valid <= r_wv; o_write_value <= r_wval;
            o_halted <= r_halt; o_error_code <= r_err; o_top_index <= r_ntop;
            o_top_value <= r_topv;
        end
    end

endmodule
